[hdl/tssc_pkg.sv]
// types, codes and crc helper for the temperature sensor scratchpad checker
package tssc_pkg;

   localparam int NUM_SENSORS = 2;

   // scratchpad is bytes 0..8, byte 8 carries the crc
   localparam logic [3:0] BYTE_TEMP_LOW  = 4'd0;
   localparam logic [3:0] BYTE_TEMP_HIGH = 4'd1;
   localparam logic [3:0] BYTE_SIX       = 4'd6;
   localparam logic [3:0] BYTE_CRC       = 4'd8;

   localparam logic REQ_NO_PRESENCE = 1'b0;
   localparam logic REQ_BYTE        = 1'b1;

   localparam logic [7:0] CRC_POLY   = 8'h8C;
   localparam logic [7:0] BLANK_LOW  = 8'h00;
   localparam logic [7:0] BLANK_HIGH = 8'hFF;
   localparam logic [7:0] COUNT_MAX  = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_PRESENCE = 2'd1,
      STATUS_BLANK       = 2'd2,
      STATUS_CRC         = 2'd3
   } tssc_status_type;

   typedef struct packed {
      logic       sensor;
      logic       req_type;
      logic [7:0] data_byte;
   } tssc_req_type;

   typedef struct packed {
      logic            sensor_out;
      tssc_status_type status;
      logic            online;
      logic [7:0]      fail_count;
      logic            negative;
      logic [7:0]      whole_degrees;
      logic [6:0]      hundredths;
   } tssc_rsp_type;

   // reflected dallas crc-8, one byte, lsb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = b;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

[hdl/temp_sensor_scratchpad_check.sv]
// scratchpad byte counter, crc-8 check and temperature decode for one-wire sensors
//
//  channel | direction | ports                          | payload
//  --------+-----------+--------------------------------+------------------------
//  req     | in        | req_valid, req_stall, req_data | sensor, kind, data byte
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data | status and decoded reading
//
// one item per cycle while req_stall is low; a result-producing item's result is in the
// output register in the cycle after it is accepted.
// synchronous active-high reset clears counters, crc, online flags and fail counts.
// req_stall rises only when the output register is full and stalled and the
// incoming item would produce a result; scratchpad bytes 0..7 still flow.
module temp_sensor_scratchpad_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tssc_pkg::tssc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tssc_pkg::tssc_rsp_type rsp_data
);

   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] temp_low_ff, temp_low_in;
   logic [7:0] temp_high_ff, temp_high_in;
   logic [7:0] byte_six_ff, byte_six_in;
   logic       online_ff [tssc_pkg::NUM_SENSORS];
   logic       online_in [tssc_pkg::NUM_SENSORS];
   logic [7:0] fail_ff [tssc_pkg::NUM_SENSORS];
   logic [7:0] fail_in [tssc_pkg::NUM_SENSORS];
   logic       rsp_valid_ff, rsp_valid_in;
   tssc_pkg::tssc_rsp_type rsp_data_ff, rsp_data_in;

   logic       in_range;
   logic       will_emit;
   logic       accept;
   logic       sel;
   logic       blank;
   logic       failed;
   logic [15:0] raw;
   logic [15:0] mag;
   logic        neg;
   logic [8:0]  frac_prod;
   tssc_pkg::tssc_rsp_type result;

   assign sel      = req_data.sensor;
   assign in_range = 32'(req_data.sensor) < tssc_pkg::NUM_SENSORS;
   assign will_emit = in_range && ((req_data.req_type == tssc_pkg::REQ_NO_PRESENCE) ||
                                   (byte_count_ff == tssc_pkg::BYTE_CRC));
   assign req_stall = rsp_valid_ff && rsp_stall && will_emit;
   assign accept    = req_valid && !req_stall;

   // decode of the captured reading
   assign raw       = {temp_high_ff, temp_low_ff};
   assign neg       = |raw[15:12];
   assign mag       = neg ? (16'd0 - raw) : raw;
   assign frac_prod = 9'(mag[3:0]) * 9'd25;
   assign blank     = ((temp_low_ff == tssc_pkg::BLANK_LOW) &&
                       (byte_six_ff == tssc_pkg::BLANK_LOW)) ||
                      ((temp_low_ff == tssc_pkg::BLANK_HIGH) &&
                       (byte_six_ff == tssc_pkg::BLANK_HIGH));

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      temp_low_in   = temp_low_ff;
      temp_high_in  = temp_high_ff;
      byte_six_in   = byte_six_ff;
      online_in     = online_ff;
      fail_in       = fail_ff;
      failed        = 1'b0;

      result.sensor_out    = sel;
      result.status        = tssc_pkg::STATUS_NO_PRESENCE;
      result.negative      = 1'b0;
      result.whole_degrees = 8'd0;
      result.hundredths    = 7'd0;

      if (req_data.req_type == tssc_pkg::REQ_NO_PRESENCE) begin
         failed = 1'b1;
      end else if (byte_count_ff == tssc_pkg::BYTE_CRC) begin
         if (blank) begin
            failed        = 1'b1;
            result.status = tssc_pkg::STATUS_BLANK;
         end else if (crc_ff != req_data.data_byte) begin
            failed        = 1'b1;
            result.status = tssc_pkg::STATUS_CRC;
         end else begin
            result.status        = tssc_pkg::STATUS_OK;
            result.negative      = neg;
            result.whole_degrees = (mag[15:12] != 4'd0) ? 8'hFF : mag[11:4];
            result.hundredths    = frac_prod[8:2];
         end
      end

      if (accept && in_range) begin
         if (will_emit) begin
            byte_count_in = 4'd0;
            crc_in        = 8'd0;
            if (failed) begin
               online_in[sel] = 1'b0;
               if (fail_ff[sel] != tssc_pkg::COUNT_MAX) begin
                  fail_in[sel] = fail_ff[sel] + 8'd1;
               end
            end else begin
               online_in[sel] = 1'b1;
            end
         end else begin
            crc_in        = tssc_pkg::crc8_byte(crc_ff, req_data.data_byte);
            byte_count_in = byte_count_ff + 4'd1;
            if (byte_count_ff == tssc_pkg::BYTE_TEMP_LOW) begin
               temp_low_in = req_data.data_byte;
            end
            if (byte_count_ff == tssc_pkg::BYTE_TEMP_HIGH) begin
               temp_high_in = req_data.data_byte;
            end
            if (byte_count_ff == tssc_pkg::BYTE_SIX) begin
               byte_six_in = req_data.data_byte;
            end
         end
      end

      result.online     = online_in[sel];
      result.fail_count = fail_in[sel];

      if (accept && will_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
         crc_ff        <= 8'd0;
         temp_low_ff   <= 8'd0;
         temp_high_ff  <= 8'd0;
         byte_six_ff   <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < tssc_pkg::NUM_SENSORS; i++) begin
            online_ff[i] <= 1'b0;
            fail_ff[i]   <= 8'd0;
         end
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         temp_low_ff   <= temp_low_in;
         temp_high_ff  <= temp_high_in;
         byte_six_ff   <= byte_six_in;
         rsp_valid_ff  <= rsp_valid_in;
         online_ff     <= online_in;
         fail_ff       <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= tssc_pkg::BYTE_CRC)
      else $error("byte count past crc byte");

   a_nopres_result: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range && req_data.req_type == tssc_pkg::REQ_NO_PRESENCE) |=>
      (rsp_valid && rsp_data.status == tssc_pkg::STATUS_NO_PRESENCE &&
       byte_count_ff == 4'd0 && crc_ff == 8'd0))
      else $error("no-presence item did not restart scratchpad");

   a_ok_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tssc_pkg::STATUS_OK) |-> rsp_data.online)
      else $error("good read left sensor offline");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != tssc_pkg::STATUS_OK) |->
      (!rsp_data.online && !rsp_data.negative && rsp_data.whole_degrees == 8'd0 &&
       rsp_data.hundredths == 7'd0 && rsp_data.fail_count != 8'd0))
      else $error("failed read carries reading or online flag");

   a_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !will_emit && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("scratchpad byte produced a result");
`endif

endmodule
